// File: hw/rtl/alr_pkg.sv
// shared constants and types for the antialiased line raster engine
package alr_pkg;

  localparam int FB_WIDTH  = 256;
  localparam int FB_HEIGHT = 256;
  localparam int DEPTH     = FB_WIDTH * FB_HEIGHT;
  localparam int COL_W     = $clog2(FB_WIDTH);
  localparam int ROW_W     = $clog2(FB_HEIGHT);
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int POS_W     = 20;

  localparam int FRAC_ONE     = 65536;
  localparam int WEIGHT_SHIFT = 10;
  localparam int WEIGHT_MAX   = 63;
  localparam int PIX_MAX      = 255;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // one queued command, line endpoints already ordered so y rises
  typedef struct packed {
    cmd_e               kind;
    logic [31:0]        xs;
    logic [31:0]        ys;
    logic signed [32:0] dx;
    logic [31:0]        dy;
    logic [7:0]         col;
    logic [7:0]         row;
    logic [7:0]         wval;
  } q_entry_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

// File: hw/rtl/alr_if.sv
// request and response channel interfaces
interface alr_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] x_start;
  logic signed [31:0] y_start;
  logic signed [31:0] x_end;
  logic signed [31:0] y_end;
  logic [7:0]         pixel_col;
  logic [7:0]         pixel_row;
  logic [7:0]         write_value;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, pixel_col, pixel_row,
                  write_value, input ready);
  modport sink (input valid, cmd, x_start, y_start, x_end, y_end, pixel_col, pixel_row,
                write_value, output ready);
endinterface

interface alr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;

  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

// File: hw/rtl/alr_ram.sv
// generic single write port, single read port ram with registered read
module alr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hw/rtl/alr_front.sv
// front end: accepts commands, orders line endpoints, queues work
module alr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  alr_req_if.sink           req_i,
  input  alr_pkg::back_stat_t stat_i,
  output logic              head_valid_o,
  output alr_pkg::q_entry_t head_o
);
  import alr_pkg::*;

  q_entry_t   q_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  q_entry_t   ent;
  logic       swap, push, acc;

  always_comb begin
    swap     = req_i.y_start > req_i.y_end;
    ent.kind = cmd_e'(req_i.cmd);
    ent.xs   = swap ? req_i.x_end : req_i.x_start;
    ent.ys   = swap ? req_i.y_end : req_i.y_start;
    ent.dx   = swap ? (33'(req_i.x_start) - 33'(req_i.x_end))
                    : (33'(req_i.x_end) - 33'(req_i.x_start));
    ent.dy   = swap ? (req_i.y_start - req_i.y_end) : (req_i.y_end - req_i.y_start);
    ent.col  = req_i.pixel_col;
    ent.row  = req_i.pixel_row;
    ent.wval = req_i.write_value;
  end

  assign req_i.ready  = (cnt_q != 2'd2) && !stat_i.clearing;
  assign acc          = req_i.valid && req_i.ready;
  // unused command code is dropped here
  assign push         = acc && (cmd_e'(req_i.cmd) != CMD_NONE);
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = q_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        q_q[wptr_q] <= ent;
        wptr_q      <= ~wptr_q;
      end
      if (stat_i.pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(stat_i.pop);
    end
  end
endmodule

// File: hw/rtl/alr_back.sv
// back end: framebuffer clear, pixel access, divider and line walker
module alr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  alr_pkg::q_entry_t   head_i,
  output alr_pkg::back_stat_t stat_o,
  alr_rsp_if.source           rsp_o
);
  import alr_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_PLAN, ST_DIV, ST_RDA, ST_RDB, ST_WRB, ST_ADV,
    ST_PIXRD, ST_PIXOUT
  } state_e;

  state_e                   state_q;
  logic [ADDR_W-1:0]        clr_q;
  logic                     rsp_valid_q;
  logic [7:0]               rsp_data_q;
  logic [ADDR_W-1:0]        pix_addr_q;
  logic                     pix_ok_q;
  logic [31:0]              xs_q, ys_q;
  logic signed [32:0]       dx_q;
  logic [31:0]              dy_q, adx_q;
  logic                     dir_q, steep_q;
  logic signed [POS_W-1:0]  px_q, py_q;
  logic [15:0]              acc_q;
  logic [16:0]              adj_q, steps_q, cnt_q, rem_q;
  logic [31:0]              div_q;
  logic [4:0]               div_cnt_q;

  logic                     we;
  logic [ADDR_W-1:0]        waddr, raddr, addr_a, addr_b, head_addr;
  logic [7:0]               wdata, rdata;
  logic                     pop, clip_ok, head_ok, carry, ge;
  logic [5:0]               wgt;
  logic [16:0]              acc_sum;
  logic [17:0]              dtrial;
  logic [31:0]              major, minor;
  logic [32:0]              steps_full;
  logic signed [POS_W-1:0]  dstep;

  function automatic logic [7:0] sat_add(logic [7:0] a, logic [5:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b);
    return s[8] ? 8'(PIX_MAX) : s[7:0];
  endfunction

  alr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    head_ok   = (32'(head_i.col) < FB_WIDTH) && (32'(head_i.row) < FB_HEIGHT);
    head_addr = ADDR_W'(32'(head_i.row) * FB_WIDTH + 32'(head_i.col));
    addr_a    = ADDR_W'(32'(py_q[ROW_W-1:0]) * FB_WIDTH + 32'(px_q[COL_W-1:0]));
    if (steep_q) begin
      addr_b = dir_q ? (addr_a - ADDR_W'(1)) : (addr_a + ADDR_W'(1));
    end else begin
      addr_b = addr_a + ADDR_W'(FB_WIDTH);
    end
    // steep lines skip column zero and the last column
    if (steep_q) begin
      clip_ok = (px_q > 0) && (py_q >= 0) &&
                (px_q < POS_W'(FB_WIDTH - 1)) && (py_q < POS_W'(FB_HEIGHT));
    end else begin
      clip_ok = (py_q >= 0) && (py_q < POS_W'(FB_HEIGHT - 1)) &&
                (px_q >= 0) && (px_q < POS_W'(FB_WIDTH));
    end
    wgt        = acc_q[15:WEIGHT_SHIFT];
    acc_sum    = 17'(acc_q) + adj_q;
    carry      = acc_sum[16];
    dstep      = dir_q ? -POS_W'(1) : POS_W'(1);
    major      = (dy_q > adx_q) ? dy_q : adx_q;
    minor      = (dy_q > adx_q) ? adx_q : dy_q;
    steps_full = (33'(major) + 33'(FRAC_ONE - 1)) >> 16;
    dtrial     = {rem_q, div_q[31]};
    ge         = dtrial >= 18'(steps_q);
  end

  assign pop = (state_q == ST_IDLE) && head_valid_i &&
               ((head_i.kind != CMD_READ) || !rsp_valid_q);

  always_comb begin
    we    = 1'b0;
    waddr = addr_a;
    wdata = 8'd0;
    raddr = addr_a;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      ST_IDLE: begin
        we    = pop && (head_i.kind == CMD_WRITE) && head_ok;
        waddr = head_addr;
        wdata = head_i.wval;
      end
      ST_RDB: begin
        raddr = addr_b;
        we    = 1'b1;
        wdata = sat_add(rdata, wgt ^ 6'(WEIGHT_MAX));
      end
      ST_WRB: begin
        we    = 1'b1;
        waddr = addr_b;
        wdata = sat_add(rdata, wgt);
      end
      ST_PIXRD: raddr = pix_addr_q;
      default: ;
    endcase
  end

  assign stat_o.clearing = state_q == ST_CLEAR;
  assign stat_o.pop      = pop;
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_value = rsp_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop && head_i.kind == CMD_DRAW) begin
            xs_q    <= head_i.xs;
            ys_q    <= head_i.ys;
            dx_q    <= head_i.dx;
            dy_q    <= head_i.dy;
            state_q <= ST_SETUP;
          end else if (pop && head_i.kind == CMD_READ) begin
            pix_addr_q <= head_addr;
            pix_ok_q   <= head_ok;
            state_q    <= ST_PIXRD;
          end
        end
        ST_SETUP: begin
          dir_q   <= dx_q[32];
          adx_q   <= dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
          px_q    <= POS_W'($signed(xs_q[31:16]));
          py_q    <= POS_W'($signed(ys_q[31:16]));
          state_q <= ST_PLAN;
        end
        ST_PLAN: begin
          steep_q   <= dy_q > adx_q;
          steps_q   <= steps_full[16:0];
          cnt_q     <= steps_full[16:0];
          acc_q     <= (dy_q > adx_q) ? xs_q[15:0] : ys_q[15:0];
          div_q     <= minor;
          rem_q     <= '0;
          div_cnt_q <= '0;
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          if (steps_q == '0) begin
            adj_q   <= '0;
            state_q <= ST_RDA;
          end else begin
            rem_q     <= ge ? 17'(dtrial - 18'(steps_q)) : dtrial[16:0];
            div_q     <= {div_q[30:0], ge};
            div_cnt_q <= div_cnt_q + 5'd1;
            if (div_cnt_q == 5'd31) begin
              adj_q   <= {div_q[15:0], ge};
              state_q <= ST_RDA;
            end
          end
        end
        ST_RDA:    state_q <= clip_ok ? ST_RDB : ST_ADV;
        ST_RDB:    state_q <= ST_WRB;
        ST_WRB:    state_q <= ST_ADV;
        ST_ADV: begin
          acc_q <= acc_sum[15:0];
          if (steep_q) begin
            py_q <= py_q + POS_W'(1);
            if (carry) begin
              px_q <= px_q + dstep;
            end
          end else begin
            px_q <= px_q + dstep;
            if (carry) begin
              py_q <= py_q + POS_W'(1);
            end
          end
          if (cnt_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            cnt_q   <= cnt_q - 17'd1;
            state_q <= ST_RDA;
          end
        end
        ST_PIXRD:  state_q <= ST_PIXOUT;
        ST_PIXOUT: begin
          rsp_data_q  <= pix_ok_q ? rdata : 8'd0;
          rsp_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/antialiased_line_raster_engine.sv
// top level: pixel read response is registered after the PIXRD and PIXOUT states
// line draw: setup and divide, then per position the RDA, RDB, WRB and ADV
// states when drawn and RDA and ADV when clipped, over step count + 1 positions
// rate is set by the single framebuffer ram, two read-modify-writes
// per position; a two-entry queue lets commands arrive while a line runs
// after reset a clear pass zeroes every framebuffer address with ready held low
module antialiased_line_raster_engine (
  input logic       clk_i,
  input logic       rst_ni,
  alr_req_if.sink   req_i,
  alr_rsp_if.source rsp_o
);
  import alr_pkg::*;

  back_stat_t stat;
  q_entry_t   head;
  logic       head_valid;

  alr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .stat_i      (stat),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  alr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .stat_o      (stat),
    .rsp_o       (rsp_o)
  );
endmodule

// File: hw/rtl/alr_checker.sv
// port level checks for the raster engine, bound to the top level
module alr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] rsp_value_i
);
  // stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_value_i))
    else $error("response dropped or changed while stalled");

  // clear pass blocks input right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !req_ready_i)
    else $error("input ready during framebuffer clear");

  // no response right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !rsp_valid_i)
    else $error("response without request after reset");

  // ready stays low for consecutive cycles while clearing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni, 2) && !$past(rst_ni) |-> !req_ready_i)
    else $error("clear pass ended too early");
endmodule

bind antialiased_line_raster_engine alr_checker u_alr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_ready_i(req_i.ready),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .rsp_value_i(rsp_o.read_value)
);
